// ----- rtl/bmsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmsa_pkg: shared types and constants of the binned mean/sigma accumulator
// Transaction formats, mode and status codes, and the request format of the
// iterative divide/square-root unit.
// ----------------------------------------------------------------------------
package bmsa_pkg;

    localparam int NUM_BINS   = 64;
    localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 55;
    localparam int CNT_W      = 24;
    localparam int RES_W      = 24;
    localparam int ENTRY_W    = SUM_W + SQ_W + CNT_W;
    localparam int DIV_W      = 70;
    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_CW    = 7;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CLEAR  = 2'd0;
    localparam t_mode MODE_ADD    = 2'd1;
    localparam t_mode MODE_REMOVE = 2'd2;
    localparam t_mode MODE_QUERY  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_BIN   = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_UNDERFLOW = 3'd3;
    localparam t_status ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         bin;
        logic signed [15:0] sample;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [RES_W-1:0]  mean;
        logic [RES_W-1:0]         sigma;
        logic [RES_W-1:0]         std_error;
        logic [CNT_W-1:0]         sample_count;
    } t_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        cnt;
    } t_entry;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_mop;

    typedef struct packed {
        logic             start;
        t_mop             op;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_mreq;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_mrsp;

endpackage
`default_nettype wire

// ----- rtl/bmsa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmsa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmsa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                        i_wdata,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/bmsa_mathu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmsa_mathu: iterative divide and square-root unit
// Restoring division, one quotient bit per cycle, and digit-by-digit integer
// square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bmsa_mathu (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bmsa_pkg::t_mreq i_req,
    output bmsa_pkg::t_mrsp      o_rsp
);
    import bmsa_pkg::*;

    logic               r_busy;
    logic               r_done;
    t_mop               r_op;
    logic [STEP_CW-1:0] r_cnt;
    logic [DIV_W-1:0]   r_src;
    logic [35:0]        r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_dvs;

    logic [CNT_W:0] d_sh;
    logic           d_ge;
    logic [CNT_W:0] d_rem;
    logic [35:0]    s_sh;
    logic [35:0]    s_trial;
    logic           s_ge;
    logic           last;

    always_comb begin
        d_sh    = {r_rem[CNT_W-1:0], r_src[DIV_W-1]};
        d_ge    = d_sh >= {1'b0, r_dvs};
        d_rem   = d_ge ? (d_sh - {1'b0, r_dvs}) : d_sh;
        s_sh    = {r_rem[33:0], r_src[SQRT_W-1:SQRT_W-2]};
        s_trial = {2'b00, r_quo[31:0], 2'b01};
        s_ge    = s_sh >= s_trial;
        last    = (r_op == OP_DIV) ? (r_cnt == STEP_CW'(DIV_W - 1))
                                   : (r_cnt == STEP_CW'(SQRT_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_src <= i_req.dividend;
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + STEP_CW'(1);
            if (r_op == OP_DIV) begin
                r_rem <= 36'(d_rem);
                r_quo <= {r_quo[DIV_W-2:0], d_ge};
                r_src <= {r_src[DIV_W-2:0], 1'b0};
            end else begin
                r_rem <= s_ge ? (s_sh - s_trial) : s_sh;
                r_quo <= {r_quo[DIV_W-2:0], s_ge};
                r_src <= {r_src[DIV_W-3:0], 2'b00};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

// ----- rtl/binned_mean_sigma_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binned_mean_sigma_accumulator: per-bin running mean and sigma
// Keeps sum, sum of squares and count for each bin in one RAM and answers
// clear, add, remove and query transactions with one result each.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. For clear, add and remove, the
// bin entry is read from the RAM in the accept cycle and written back in the
// next. A query walks through a shared iterative unit that does one bit per
// cycle: the mean division (70 steps), the mean-square division (70 steps),
// the sigma square root (32 steps), the square root of the count (32 steps)
// and the standard-error division (70 steps). Each pass but the last is
// followed by the next one being started in the cycle that the unit raises
// its done flag, except that after the mean-square division a separate step
// first compares the mean square with the squared mean. Queries that end
// early (empty bin, no positive variance) skip the remaining passes. Every
// bin reads as empty right after reset, through one valid flag per bin, so
// no clearing pass is needed. A finished result sits in an output register,
// and the block takes the next transaction while that result waits to be taken.
// ----------------------------------------------------------------------------
module binned_mean_sigma_accumulator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bmsa_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bmsa_pkg::t_out     o_out
);
    import bmsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_MEAN = 9'b000000100,
        S_MS   = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_SIG  = 9'b000100000,
        S_ROOT = 9'b001000000,
        S_ERR  = 9'b010000000,
        S_HOLD = 9'b100000000
    } t_state;

    localparam logic [RES_W-1:0] MEAN_POS_MAX = 24'h7FFFFF;
    localparam logic [RES_W-1:0] MEAN_NEG_MAX = 24'h800000;
    localparam logic [RES_W-1:0] SAT24        = 24'hFFFFFF;

    t_state               r_state, n_state;
    t_in                  r_item;
    logic [31:0]          r_s2;
    logic                 r_ov, n_ov;
    t_out                 r_out;
    t_out                 r_res, n_res;
    logic [NUM_BINS-1:0]  r_vld;
    logic                 r_neg, n_neg;
    logic [RES_W-1:0]     r_am, n_am;
    logic [62:0]          r_ms, n_ms;
    logic [46:0]          r_msq, n_msq;
    logic [RES_W-1:0]     r_sigma, n_sigma;
    t_entry               r_ent, n_ent;

    logic                 accept;
    logic                 bin_ok;
    logic [BIN_AW-1:0]    idx;
    logic [ENTRY_W-1:0]   rdata;
    t_entry               ent_rd;
    logic                 w_we;
    t_entry               w_data;
    t_mreq                mreq;
    t_mrsp                mrsp;
    logic                 fin;
    logic                 load;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign idx    = r_item.bin[BIN_AW-1:0];
    assign bin_ok = {1'b0, r_item.bin} < 9'(NUM_BINS);
    assign ent_rd = r_vld[idx] ? t_entry'(rdata) : '0;

    bmsa_ram #(
        .W(ENTRY_W),
        .D(NUM_BINS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(idx),
        .i_wdata(w_data),
        .i_raddr(i_in.bin[BIN_AW-1:0]),
        .o_rdata(rdata)
    );

    bmsa_mathu u_mathu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rsp  (mrsp)
    );

    // Sequencer: the accept cycle reads the bin, the execute cycle decides,
    // and a query then steps through the shared divide/square-root unit.
    always_comb begin
        logic [47:0]       sh;
        logic [RES_W-1:0]  am;
        logic [31:0]       sg;
        n_state = r_state;
        n_res   = r_res;
        n_neg   = r_neg;
        n_am    = r_am;
        n_ms    = r_ms;
        n_msq   = r_msq;
        n_sigma = r_sigma;
        n_ent   = r_ent;
        mreq    = '0;
        fin     = 1'b0;
        w_we    = 1'b0;
        w_data  = '0;
        sh      = '0;
        am      = '0;
        sg      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res = '0;
                n_ent = ent_rd;
                if (!bin_ok) begin
                    n_res.status = ST_BAD_BIN;
                    fin = 1'b1;
                end else begin
                    case (r_item.mode)
                        MODE_CLEAR: begin
                            w_we = 1'b1;
                            fin  = 1'b1;
                        end
                        MODE_ADD: begin
                            fin = 1'b1;
                            if (ent_rd.cnt == SAT24) begin
                                n_res.status       = ST_OVERFLOW;
                                n_res.sample_count = ent_rd.cnt;
                            end else begin
                                w_we       = 1'b1;
                                w_data.sum = ent_rd.sum + SUM_W'(r_item.sample);
                                w_data.sq  = ent_rd.sq + SQ_W'(r_s2);
                                w_data.cnt = ent_rd.cnt + CNT_W'(1);
                                n_res.sample_count = w_data.cnt;
                            end
                        end
                        MODE_REMOVE: begin
                            fin = 1'b1;
                            if (ent_rd.cnt == '0) begin
                                n_res.status = ST_UNDERFLOW;
                            end else begin
                                w_we       = 1'b1;
                                w_data.sum = ent_rd.sum - SUM_W'(r_item.sample);
                                w_data.sq  = ent_rd.sq - SQ_W'(r_s2);
                                w_data.cnt = ent_rd.cnt - CNT_W'(1);
                                n_res.sample_count = w_data.cnt;
                            end
                        end
                        MODE_QUERY: begin
                            n_res.sample_count = ent_rd.cnt;
                            if (ent_rd.cnt == '0) begin
                                n_res.status = ST_EMPTY;
                                fin = 1'b1;
                            end else begin
                                sh    = {ent_rd.sum, 8'b0};
                                n_neg = ent_rd.sum[SUM_W-1];
                                mreq.start    = 1'b1;
                                mreq.op       = OP_DIV;
                                mreq.dividend = DIV_W'(n_neg ? 48'(~sh + 48'd1) : sh);
                                mreq.divisor  = ent_rd.cnt;
                                n_state = S_MEAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_MEAN: begin
                if (mrsp.done) begin
                    if (!r_neg) begin
                        am = (mrsp.quo > DIV_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX
                                                               : mrsp.quo[RES_W-1:0];
                    end else begin
                        am = (mrsp.quo > DIV_W'(MEAN_NEG_MAX)) ? MEAN_NEG_MAX
                                                               : mrsp.quo[RES_W-1:0];
                    end
                    n_am       = am;
                    n_res.mean = r_neg ? RES_W'(~am + RES_W'(1)) : am;
                    // A sum of squares that reads as negative or zero means no spread.
                    if (!r_ent.sq[SQ_W-1] && (r_ent.sq != '0)) begin
                        mreq.start    = 1'b1;
                        mreq.op       = OP_DIV;
                        mreq.dividend = {r_ent.sq[SQ_W-2:0], 16'b0};
                        mreq.divisor  = r_ent.cnt;
                        n_state = S_MS;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_MS: begin
                if (mrsp.done) begin
                    // The integer part of the mean square is clamped at 2^46.
                    if (mrsp.quo[DIV_W-1:16] > 54'(64'd1 << 46)) begin
                        n_ms = {1'b1, 46'b0, mrsp.quo[15:0]};
                    end else begin
                        n_ms = mrsp.quo[62:0];
                    end
                    n_msq   = 47'(r_am * r_am);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_ms > 63'(r_msq)) begin
                    mreq.start    = 1'b1;
                    mreq.op       = OP_SQRT;
                    mreq.dividend = DIV_W'(r_ms - 63'(r_msq));
                    n_state = S_SIG;
                end else begin
                    fin = 1'b1;
                end
            end
            S_SIG: begin
                if (mrsp.done) begin
                    sg            = mrsp.quo[31:0];
                    n_sigma       = (sg[31:24] != '0) ? SAT24 : sg[23:0];
                    n_res.sigma   = n_sigma;
                    mreq.start    = 1'b1;
                    mreq.op       = OP_SQRT;
                    mreq.dividend = DIV_W'({r_ent.cnt, 24'b0});
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (mrsp.done) begin
                    mreq.start    = 1'b1;
                    mreq.op       = OP_DIV;
                    mreq.dividend = DIV_W'({r_sigma, 12'b0});
                    mreq.divisor  = mrsp.quo[CNT_W-1:0];
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                if (mrsp.done) begin
                    n_res.std_error = mrsp.quo[RES_W-1:0];
                    fin = 1'b1;
                end
            end
            S_HOLD: begin
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        load = fin && (!r_ov || !i_out_stall);
        if (fin) begin
            n_state = load ? S_IDLE : S_HOLD;
        end
        n_ov = load || (r_ov && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (w_we) begin
                r_vld[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
            r_s2   <= 32'(i_in.sample * i_in.sample);
        end
        if (load) begin
            r_out <= n_res;
        end
        r_res   <= n_res;
        r_neg   <= n_neg;
        r_am    <= n_am;
        r_ms    <= n_ms;
        r_msq   <= n_msq;
        r_sigma <= n_sigma;
        r_ent   <= n_ent;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_write_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_EXEC) && bin_ok))
        else $error("bin RAM written outside the execute step or for a bad bin");

    a_math_done_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mrsp.done |-> ((r_state == S_MEAN) || (r_state == S_MS) || (r_state == S_SIG)
                       || (r_state == S_ROOT) || (r_state == S_ERR)))
        else $error("math unit finished while no query step was waiting");

    a_failed_has_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_OK)) |->
            ((o_out.mean == '0) && (o_out.sigma == '0) && (o_out.std_error == '0)))
        else $error("result with error status carries statistics");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the binned mean/sigma accumulator
// Drives clear, add, remove and query transactions with random gaps and
// output stalls. Every accepted transaction is run through a bin-statistics
// predictor, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import bmsa_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int N_DIRECTED   = 22;
    localparam int IN_W         = $bits(t_in);

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    binned_mean_sigma_accumulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The predictor keeps its own copy of every bin.
    logic signed [SUM_W-1:0] bin_sum_q [NUM_BINS];
    logic [SQ_W-1:0]         bin_sq_q  [NUM_BINS];
    logic [CNT_W-1:0]        bin_cnt_q [NUM_BINS];

    // Results still owed by the block, oldest first.
    t_out pending_results[$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned results_seen;
    int unsigned status_seen [5];
    int unsigned nonzero_sigma_seen;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out result;
    } t_row;

    t_row directed_rows [N_DIRECTED];

    // Bitwise integer square root, rounded down.
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Applies one transaction to the bin copy and returns the result it gives.
    function automatic t_out apply_bin_update(t_in x);
        t_out            r;
        int unsigned     b;
        longint          sv;
        longint          sumv;
        longint          sqv;
        longint          nn;
        longint          m;
        longint unsigned usq;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned am;
        longint unsigned ms;
        longint unsigned msq;
        longint unsigned sg;
        longint unsigned root;
        r  = '0;
        b  = x.bin;
        sv = x.sample;
        if (b >= NUM_BINS) begin
            r.status = ST_BAD_BIN;
            return r;
        end
        r.status = ST_OK;
        case (x.mode)
            MODE_CLEAR: begin
                bin_sum_q[b] = '0;
                bin_sq_q[b]  = '0;
                bin_cnt_q[b] = '0;
            end
            MODE_ADD: begin
                if (bin_cnt_q[b] == {CNT_W{1'b1}}) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    bin_sum_q[b] = bin_sum_q[b] + SUM_W'(sv);
                    bin_sq_q[b]  = bin_sq_q[b] + SQ_W'(sv * sv);
                    bin_cnt_q[b] = bin_cnt_q[b] + 1'b1;
                end
                r.sample_count = bin_cnt_q[b];
            end
            MODE_REMOVE: begin
                if (bin_cnt_q[b] == '0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    bin_sum_q[b] = bin_sum_q[b] - SUM_W'(sv);
                    bin_sq_q[b]  = bin_sq_q[b] - SQ_W'(sv * sv);
                    bin_cnt_q[b] = bin_cnt_q[b] - 1'b1;
                end
                r.sample_count = bin_cnt_q[b];
            end
            default: begin
                r.sample_count = bin_cnt_q[b];
                if (bin_cnt_q[b] == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    nn   = bin_cnt_q[b];
                    sumv = bin_sum_q[b];
                    sqv  = longint'($signed(bin_sq_q[b]));
                    m    = (sumv * 256) / nn;
                    if (m > 8388607) m = 8388607;
                    if (m < -8388608) m = -8388608;
                    r.mean = m[RES_W-1:0];
                    if (sqv > 0) begin
                        usq = sqv;
                        q   = usq / nn;
                        rem = usq % nn;
                        if (q > (64'd1 << 46)) q = 64'd1 << 46;
                        ms  = (q << 16) + ((rem << 16) / nn);
                        am  = (m < 0) ? -m : m;
                        msq = am * am;
                        if (ms > msq) begin
                            sg = int_sqrt(ms - msq);
                            if (sg > 64'hFF_FFFF) sg = 64'hFF_FFFF;
                            root = int_sqrt(longint'(nn) << 24);
                            r.sigma     = sg[RES_W-1:0];
                            r.std_error = RES_W'((sg << 12) / root);
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed.",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own: it switches between never
    // stalling, stalling at random, and a fixed on/off rhythm, so stalls land
    // on every phase of a query.
    int unsigned stall_style;
    int unsigned stall_phase;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_style <= 0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 250 == 0) stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 99) < 35);
                2: i_out_stall <= (stall_phase % 7) < 3;
                default: i_out_stall <= ($urandom_range(0, 99) < 80);
            endcase
        end
    end

    // Result checker: each transaction on the output side is compared with
    // the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no expectation waiting: %p", $time, o_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.status <= ST_OVERFLOW) status_seen[want.status]++;
                if (want.sigma != '0) nonzero_sigma_seen++;
                if (o_out.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out.status);
                    error_count++;
                end
                if (o_out.mean !== want.mean) begin
                    $display("%0t: mean expected %0d actual %0d",
                             $time, want.mean, o_out.mean);
                    error_count++;
                end
                if (o_out.sigma !== want.sigma) begin
                    $display("%0t: sigma expected %0d actual %0d",
                             $time, want.sigma, o_out.sigma);
                    error_count++;
                end
                if (o_out.std_error !== want.std_error) begin
                    $display("%0t: std_error expected %0d actual %0d",
                             $time, want.std_error, o_out.std_error);
                    error_count++;
                end
                if (o_out.sample_count !== want.sample_count) begin
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, want.sample_count, o_out.sample_count);
                    error_count++;
                end
            end
        end
    end

    // Sends one transaction and records what it should produce. Valid is
    // raised at a falling edge and held until a rising edge with no stall.
    // When a row carries a typed result, that value is expected, but the
    // predictor still runs so the bin copy stays in step.
    task automatic send_item(t_in x, bit typed, t_out typed_result);
        t_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= x;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_bin_update(x);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Drops valid for a number of cycles; the payload wanders meanwhile.
    task automatic idle_sender(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in       <= t_in'(IN_W'($urandom));
        end
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random transaction: mostly well-formed work on a few busy bins so that
    // counts grow and queries see real statistics, plus some noise.
    function automatic t_in random_item();
        t_in         x;
        int unsigned pick;
        x.sample = 16'($urandom);
        pick     = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 75) x.bin = 8'($urandom_range(0, 5));
        else x.bin = 8'($urandom_range(0, NUM_BINS - 1));
        if (pick < 48) x.mode = MODE_ADD;
        else if (pick < 73) x.mode = MODE_QUERY;
        else if (pick < 88) x.mode = MODE_REMOVE;
        else if (pick < 93) x.mode = MODE_CLEAR;
        else begin
            x.mode = t_mode'($urandom_range(0, 3));
            x.bin  = 8'($urandom_range(NUM_BINS, 255));
        end
        // Small samples give modest variances next to the full-range ones.
        if ($urandom_range(0, 2) == 0)
            x.sample = 16'($signed(16'($urandom_range(0, 200))) - 100);
        return x;
    endfunction

    function automatic t_row make_row(t_mode mode, int bin, int sample, bit typed,
                                      t_status status, int mean, int cnt);
        t_row r;
        r.item.mode          = mode;
        r.item.bin           = 8'(bin);
        r.item.sample        = 16'(sample);
        r.typed              = typed;
        r.result             = '0;
        r.result.status      = status;
        r.result.mean        = RES_W'(mean);
        r.result.sample_count = CNT_W'(cnt);
        return r;
    endfunction

    initial begin
        int unsigned burst;
        t_row        row;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in               = '0;
        i_out_stall        = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        results_seen       = 0;
        nonzero_sigma_seen = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        for (int k = 0; k < NUM_BINS; k++) begin
            bin_sum_q[k] = '0;
            bin_sq_q[k]  = '0;
            bin_cnt_q[k] = '0;
        end

        // Directed rows: empty bins after reset, invalid bins at both ends,
        // underflow, a single sample with no spread, full-scale samples,
        // removal of a sample that was never added, and clears.
        directed_rows[0]  = make_row(MODE_QUERY,  0,   0,      1, ST_EMPTY,     0,     0);
        directed_rows[1]  = make_row(MODE_ADD,    64,  -1,     1, ST_BAD_BIN,   0,     0);
        directed_rows[2]  = make_row(MODE_QUERY,  255, 0,      1, ST_BAD_BIN,   0,     0);
        directed_rows[3]  = make_row(MODE_REMOVE, 1,   5,      1, ST_UNDERFLOW, 0,     0);
        directed_rows[4]  = make_row(MODE_CLEAR,  2,   0,      1, ST_OK,        0,     0);
        directed_rows[5]  = make_row(MODE_ADD,    4,   100,    1, ST_OK,        0,     1);
        directed_rows[6]  = make_row(MODE_QUERY,  4,   0,      1, ST_OK,        25600, 1);
        directed_rows[7]  = make_row(MODE_ADD,    3,   32767,  0, ST_OK,        0,     0);
        directed_rows[8]  = make_row(MODE_ADD,    3,   -32768, 0, ST_OK,        0,     0);
        directed_rows[9]  = make_row(MODE_QUERY,  3,   0,      0, ST_OK,        0,     0);
        directed_rows[10] = make_row(MODE_ADD,    5,   0,      0, ST_OK,        0,     0);
        directed_rows[11] = make_row(MODE_ADD,    5,   0,      0, ST_OK,        0,     0);
        directed_rows[12] = make_row(MODE_REMOVE, 5,   1000,   0, ST_OK,        0,     0);
        directed_rows[13] = make_row(MODE_QUERY,  5,   0,      0, ST_OK,        0,     0);
        directed_rows[14] = make_row(MODE_ADD,    63,  -1,     0, ST_OK,        0,     0);
        directed_rows[15] = make_row(MODE_ADD,    63,  7,      0, ST_OK,        0,     0);
        directed_rows[16] = make_row(MODE_ADD,    63,  -32768, 0, ST_OK,        0,     0);
        directed_rows[17] = make_row(MODE_QUERY,  63,  0,      0, ST_OK,        0,     0);
        directed_rows[18] = make_row(MODE_CLEAR,  3,   0,      1, ST_OK,        0,     0);
        directed_rows[19] = make_row(MODE_QUERY,  3,   0,      1, ST_EMPTY,     0,     0);
        directed_rows[20] = make_row(MODE_REMOVE, 4,   100,    1, ST_OK,        0,     0);
        directed_rows[21] = make_row(MODE_QUERY,  4,   0,      1, ST_EMPTY,     0,     0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_item(row.item, row.typed, row.result);
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 4));
        end

        // Hold off until the directed part has fully drained.
        idle_sender(1);
        wait_for_results();

        // Random part: bursts of back-to-back transactions with gaps between.
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
                send_item(random_item(), 1'b0, '0);
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
            if (n >= RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + burst) begin
                idle_sender(1);
                wait_for_results();
            end
        end

        idle_sender(1);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d invalid bin, %0d empty, %0d underflow.",
                 results_seen, status_seen[ST_OK], status_seen[ST_BAD_BIN],
                 status_seen[ST_EMPTY], status_seen[ST_UNDERFLOW]);
        $display("Queries with a nonzero sigma: %0d; mismatches: %0d.",
                 nonzero_sigma_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bmsa_pkg.sv
rtl/bmsa_ram.sv
rtl/bmsa_mathu.sv
rtl/binned_mean_sigma_accumulator.sv
tb/sv/testbench.sv
